// File: design/gpqs_pkg.sv
package gpqs_pkg;

	// Width of the norm register and of the quotient that bounds a cross-off.
	localparam int unsigned NORM_W = 16;
	// Width of the norm of an input point, a*a + b*b with 8-bit parts.
	localparam int unsigned PNORM_W = 17;
	localparam int unsigned COORD_W = 8;
	localparam logic [NORM_W-1:0] MAX_NORM_RESET = 16'd65025;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_CROSS = 2'd1,
		CMD_READ  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

endpackage

// File: design/gaussian_prime_quadrant_sieve.sv
// Prime sieve over the first-quadrant Gaussian integers a+bi, one flag bit per
// point kept in a single-port-write, single-port-read bitmap memory. A request
// carries a command in tuser (0 init, 1 cross off the multiples of a prime,
// 2 read one point) and the point a+bi in tdata; every request yields exactly
// one response with the read flag and an error bit for a zero-norm prime.
// After reset a clearing pass zeroes the bitmap before the first request is
// taken. Init sweeps the whole square. A cross-off computes the norm and runs
// the 16-step divider, then walks the multiples of the prime row by row of the
// c loop and writes those that fall inside the square; a small prime has the
// longest walk. The max_norm register is written on the cfg channel; the user
// must write it only while no request is in flight, and the block itself does
// not enforce it.
module gaussian_prime_quadrant_sieve #(
	parameter int unsigned SIDE = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: max_norm.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// Requests.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [7:0] prime_re, [15:8] prime_im
	input  logic [1:0]  s_tuser,  // [1:0] command
	// Responses.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // [0] prime_flag, [1] error, rest zero
);
	import gpqs_pkg::*;

	localparam int unsigned CW = $clog2(SIDE);
	localparam int unsigned AW = 2 * CW;
	localparam int unsigned NW = 2 * CW + 1;
	localparam int unsigned SW = (NW > NORM_W) ? NW : NORM_W;
	localparam int unsigned XW = 11;  // signed width of a product coordinate
	localparam int unsigned KW = 18;  // width of c*c and d*d accumulators

	typedef enum logic [11:0] {
		ST_CLEAR = 12'b000000000001,
		ST_IDLE  = 12'b000000000010,
		ST_SWEEP = 12'b000000000100,
		ST_NORM1 = 12'b000000001000,
		ST_NORM2 = 12'b000000010000,
		ST_DIV   = 12'b000000100000,
		ST_CROSS = 12'b000001000000,
		ST_MARK  = 12'b000010000000,
		ST_RD    = 12'b000100000000,
		ST_DONE  = 12'b001000000000,
		ST_DISP  = 12'b010000000000,
		ST_START = 12'b100000000000
	} state_t;

	state_t state_q;

	logic [NORM_W-1:0]   max_norm_q;
	cmd_t                cmd_q;
	logic [COORD_W-1:0]  are_q;
	logic [COORD_W-1:0]  aim_q;
	logic [PNORM_W-1:0]  nrm_q;
	logic                res_flag_q;
	logic                res_err_q;

	// Sweep counters for clearing and init; aa/bb track sa*sa and sb*sb.
	logic [CW-1:0] sa_q;
	logic [CW-1:0] sb_q;
	logic [NW-1:0] aa_q;
	logic [NW-1:0] bb_q;

	// Cross-off walk: c and d with their squares, and the running product u+vi.
	logic [8:0]           c_q;
	logic [8:0]           d_q;
	logic [KW-1:0]        cc_q;
	logic [KW-1:0]        dd_q;
	logic signed [XW-1:0] u_q;
	logic signed [XW-1:0] v_q;
	logic signed [XW-1:0] ac_q;
	logic signed [XW-1:0] bc_q;
	logic [NORM_W-1:0]    q_q;

	logic                out_valid_q;
	logic                out_flag_q;
	logic                out_err_q;

	logic                div_start;
	logic                div_done;
	logic [NORM_W-1:0]   div_quo;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic                mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic                mem_rdata;

	logic                sweep_last;
	logic [SW-1:0]       sweep_norm;
	logic                row_ok;
	logic signed [XW-1:0] px;
	logic signed [XW-1:0] py;
	logic                p_in;
	logic [CW-1:0]       px_w;
	logic [CW-1:0]       py_w;
	logic                pt_in;
	logic                nrm_ok;
	logic                s_acc;
	logic                out_free;

	gpqs_bitmap #(.AW(AW)) u_bitmap (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gpqs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (max_norm_q),
		.divisor  (nrm_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_acc     = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_err_q, out_flag_q};

	// The sweep ends at the far corner of the square.
	assign sweep_last = (sa_q == CW'(SIDE - 1)) && (sb_q == CW'(SIDE - 1));
	assign sweep_norm = SW'(aa_q) + SW'(bb_q);

	// A multiple u+vi with u <= 0 is stored as v + (-u)i.
	assign row_ok = (KW'(cc_q) + KW'(dd_q)) <= KW'(q_q);
	assign px     = (u_q > 0) ? u_q : v_q;
	assign py     = (u_q > 0) ? v_q : -u_q;
	assign p_in   = (px >= 0) && (py >= 0) && (int'(px) < int'(SIDE)) &&
		(int'(py) < int'(SIDE));
	assign px_w   = CW'($unsigned(px));
	assign py_w   = CW'($unsigned(py));

	// The input point lies inside the stored square and within max_norm.
	assign pt_in  = (int'(are_q) < int'(SIDE)) && (int'(aim_q) < int'(SIDE));
	assign nrm_ok = nrm_q <= PNORM_W'(max_norm_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = {sa_q, sb_q};
		mem_wdata = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				// Zero, one and i have norm at most one and are never prime.
				mem_wdata = (sweep_norm <= SW'(max_norm_q)) && (sweep_norm > SW'(1));
			end
			ST_CROSS: begin
				mem_we    = row_ok && p_in;
				mem_waddr = {px_w, py_w};
			end
			ST_MARK: begin
				mem_we    = nrm_ok && pt_in;
				mem_waddr = {CW'(are_q), CW'(aim_q)};
				mem_wdata = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_re    = (state_q == ST_DISP);
	assign mem_raddr = {CW'(are_q), CW'(aim_q)};
	assign div_start = (state_q == ST_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_norm_q <= MAX_NORM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_norm_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
			sa_q        <= '0;
			sb_q        <= '0;
		end else begin
			// A finished request loads the response register once it is free.
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR, ST_SWEEP: begin
					if (sweep_last) begin
						sa_q    <= '0;
						sb_q    <= '0;
						state_q <= (state_q == ST_CLEAR) ? ST_IDLE : ST_DONE;
					end else if (sb_q == CW'(SIDE - 1)) begin
						sb_q <= '0;
						sa_q <= sa_q + 1'b1;
					end else begin
						sb_q <= sb_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						state_q <= (cmd_t'(s_tuser) == CMD_INIT) ? ST_SWEEP : ST_NORM1;
					end
				end
				ST_NORM1: begin
					state_q <= ST_NORM2;
				end
				ST_NORM2: begin
					state_q <= ST_DISP;
				end
				ST_DISP: begin
					case (cmd_q)
						CMD_READ:  state_q <= ST_RD;
						CMD_CROSS: state_q <= (nrm_q == '0) ? ST_DONE : ST_START;
						default:   state_q <= ST_DONE;
					endcase
				end
				ST_START: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_CROSS;
					end
				end
				ST_CROSS: begin
					// A failed bound with d at zero means c has run out as well.
					if (!row_ok && (d_q == '0)) begin
						state_q <= ST_MARK;
					end
				end
				ST_MARK, ST_RD: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload and datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_flag_q <= res_flag_q;
			out_err_q  <= res_err_q;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					cmd_q      <= cmd_t'(s_tuser);
					are_q      <= s_tdata[7:0];
					aim_q      <= s_tdata[15:8];
					res_flag_q <= 1'b0;
					res_err_q  <= 1'b0;
				end
				aa_q <= '0;
				bb_q <= '0;
			end
			ST_CLEAR, ST_SWEEP: begin
				if (sb_q == CW'(SIDE - 1)) begin
					bb_q <= '0;
					aa_q <= aa_q + NW'({sa_q, 1'b1});
				end else begin
					bb_q <= bb_q + NW'({sb_q, 1'b1});
				end
			end
			ST_NORM1: begin
				nrm_q <= PNORM_W'(are_q) * PNORM_W'(are_q);
			end
			ST_NORM2: begin
				nrm_q <= nrm_q + PNORM_W'(aim_q) * PNORM_W'(aim_q);
			end
			ST_DISP: begin
				if (cmd_q == CMD_CROSS && nrm_q == '0) begin
					res_err_q <= 1'b1;
				end
			end
			ST_DIV: begin
				q_q  <= div_quo;
				c_q  <= 9'd1;
				d_q  <= '0;
				cc_q <= KW'(1);
				dd_q <= '0;
				u_q  <= XW'($signed({1'b0, are_q}));
				v_q  <= XW'($signed({1'b0, aim_q}));
				ac_q <= XW'($signed({1'b0, are_q}));
				bc_q <= XW'($signed({1'b0, aim_q}));
			end
			ST_CROSS: begin
				if (row_ok) begin
					// Next d: u -= b, v += a, d*d grows by 2d+1.
					d_q  <= d_q + 1'b1;
					dd_q <= dd_q + KW'({d_q, 1'b1});
					u_q  <= u_q - XW'($signed({1'b0, aim_q}));
					v_q  <= v_q + XW'($signed({1'b0, are_q}));
				end else begin
					// Next c with d back at zero: u+vi = (a+bi)c.
					c_q  <= c_q + 1'b1;
					cc_q <= cc_q + KW'({c_q, 1'b1});
					d_q  <= '0;
					dd_q <= '0;
					ac_q <= ac_q + XW'($signed({1'b0, are_q}));
					bc_q <= bc_q + XW'($signed({1'b0, aim_q}));
					u_q  <= ac_q + XW'($signed({1'b0, are_q}));
					v_q  <= bc_q + XW'($signed({1'b0, aim_q}));
				end
			end
			ST_RD: begin
				res_flag_q <= mem_rdata && nrm_ok && pt_in;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: design/gpqs_div.sv
module gpqs_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [gpqs_pkg::NORM_W-1:0]         dividend,
	input  logic [gpqs_pkg::PNORM_W-1:0]        divisor,
	output logic                                done,
	output logic [gpqs_pkg::NORM_W-1:0]         quotient
);
	import gpqs_pkg::*;

	localparam int unsigned CNT_W = $clog2(NORM_W + 1);

	logic [PNORM_W-1:0] rem_q;
	logic [PNORM_W-1:0] dvs_q;
	logic [NORM_W-1:0]  quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [PNORM_W:0]   trial;
	logic               take;

	// One quotient bit per cycle, restoring form.
	assign trial = {rem_q, quo_q[NORM_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NORM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? PNORM_W'(trial - {1'b0, dvs_q}) : trial[PNORM_W-1:0];
			quo_q <= {quo_q[NORM_W-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: design/gpqs_bitmap.sv
module gpqs_bitmap #(
	parameter int unsigned AW = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);
	logic mem_q [2**AW];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: dv/gpqs_checker.sv
module gpqs_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	output int          failures,
	output int          pending
);
	import gpqs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic flag;
		logic err;
	} sieve_resp_t;

	bit          cand_map [0:65535];
	logic [15:0] norm_limit;
	sieve_resp_t resp_queue [$];

	function automatic void mark(int a, int b, bit v);
		if (a >= 0 && b >= 0 && a < 256 && b < 256)
			cand_map[a * 256 + b] = v;
	endfunction

	function automatic sieve_resp_t predict_response(cmd_t cmd, int a, int b);
		sieve_resp_t r;
		int unsigned n;
		int unsigned q;
		int u;
		int v;
		r = '0;
		n = a * a + b * b;
		case (cmd)
			CMD_INIT: begin
				for (int x = 0; x < 256; x++)
					for (int y = 0; y < 256; y++)
						mark(x, y, (x * x + y * y) <= norm_limit);
				mark(0, 0, 0);
				mark(1, 0, 0);
				mark(0, 1, 0);
			end
			CMD_CROSS: begin
				if (n == 0) begin
					r.err = 1'b1;
				end else begin
					q = norm_limit / n;
					for (int c = 1; c * c <= q; c++) begin
						for (int d = 0; c * c + d * d <= q; d++) begin
							u = a * c - b * d;
							v = b * c + a * d;
							// Multiples off the quadrant are turned back into it by -i.
							if (u > 0) mark(u, v, 0);
							else mark(v, -u, 0);
						end
					end
					if (n <= norm_limit)
						mark(a, b, 1);
				end
			end
			CMD_READ: begin
				r.flag = (n <= norm_limit) && cand_map[a * 256 + b];
			end
			default: ;
		endcase
		return r;
	endfunction

	initial begin
		foreach (cand_map[i])
			cand_map[i] = 0;
	end

	assign pending = resp_queue.size();

	always @(posedge clk or negedge arst_n) begin
		sieve_resp_t want;
		if (!arst_n) begin
			norm_limit = MAX_NORM_RESET;
			failures   = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				norm_limit = cfg_data;
			if (s_tvalid && s_tready)
				resp_queue = {resp_queue, predict_response(cmd_t'(s_tuser),
					int'(s_tdata[7:0]), int'(s_tdata[15:8]))};
			if (m_tvalid && m_tready) begin
				if (resp_queue.size() == 0) begin
					$error("response with nothing outstanding: %h", m_tdata);
					failures++;
				end else begin
					want = resp_queue.pop_front();
					if (m_tdata[0] !== want.flag) begin
						$error("prime_flag: expected %0d, actual %0d", want.flag, m_tdata[0]);
						failures++;
					end
					if (m_tdata[1] !== want.err) begin
						$error("error: expected %0d, actual %0d", want.err, m_tdata[1]);
						failures++;
					end
				end
			end
		end
	end
endmodule

// File: dv/gaussian_prime_quadrant_sieve_tb.sv
module gaussian_prime_quadrant_sieve_tb;
	import gpqs_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;  // [7:0] prime_re, [15:8] prime_im
	logic [1:0]  s_tuser = '0;  // [1:0] command
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [7:0]  m_tdata;       // [0] prime_flag, [1] error
	int          failures;
	int          pending;

	// Once set, both sides run without idle cycles.
	bit          calm = 0;
	logic [15:0] cur_limit = MAX_NORM_RESET;
	int          n_init, n_cross, n_read, n_other, n_cfg;

	gaussian_prime_quadrant_sieve u_top (.*);

	gpqs_checker u_chk (.*);

	always #6 clk = ~clk;

	// The response side holds tready high or low in random bursts.
	initial begin
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!calm && $urandom_range(0, 1)) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
			end
		end
	end

	// Hard stop in case the block hangs.
	initial begin
		#60ms;
		$display("status: fail");
		$finish;
	end

	// Issue one request, sometimes after an idle burst on the request side.
	task automatic send_request(cmd_t cmd, logic [7:0] re, logic [7:0] im);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {im, re};
		do @(posedge clk); while (!s_tready);
		case (cmd)
			CMD_INIT:  n_init++;
			CMD_CROSS: n_cross++;
			CMD_READ:  n_read++;
			default:   n_other++;
		endcase
	endtask

	// The register is only touched once every outstanding request has answered.
	task automatic write_limit(logic [15:0] value);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_limit = value;
		n_cfg++;
	endtask

	// Largest coordinate that can still lie inside the quarter disk.
	function automatic int disk_radius(logic [15:0] lim);
		int r;
		r = 0;
		while (r < 255 && (r + 1) * (r + 1) <= lim) r++;
		return r;
	endfunction

	// One random request. Cross-offs whose quotient would make the block
	// walk thousands of multiples are turned into reads to keep runtime sane.
	task automatic random_request();
		int sel;
		int r;
		int a;
		int b;
		int unsigned n;
		sel = $urandom_range(0, 99);
		r = disk_radius(cur_limit);
		if ($urandom_range(0, 1)) begin
			a = $urandom_range(0, r);
			b = $urandom_range(0, r);
		end else begin
			a = $urandom_range(0, 255);
			b = $urandom_range(0, 255);
		end
		n = a * a + b * b;
		if (sel < 40 && (n == 0 || cur_limit / n <= 3000))
			send_request(CMD_CROSS, 8'(a), 8'(b));
		else if (sel < 95)
			send_request(CMD_READ, 8'(a), 8'(b));
		else
			send_request(CMD_NONE, 8'(a), 8'(b));
	endtask

	initial begin
		logic [15:0] limits [5] = '{16'd0, 16'd65535, 16'd1200, 16'd20000, 16'd9};
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset value of max_norm. The first request
		// waits out the clearing pass that follows reset.
		send_request(CMD_READ, 8'd3, 8'd4);      // bitmap still clear
		send_request(CMD_INIT, 8'd0, 8'd0);
		send_request(CMD_READ, 8'd0, 8'd0);
		send_request(CMD_READ, 8'd1, 8'd0);
		send_request(CMD_READ, 8'd0, 8'd1);
		send_request(CMD_READ, 8'd255, 8'd0);    // exactly on the rim
		send_request(CMD_READ, 8'd255, 8'd255);  // far outside the disk
		send_request(CMD_CROSS, 8'd0, 8'd0);     // zero norm is an error
		send_request(CMD_CROSS, 8'd1, 8'd1);     // smallest prime, longest walk
		send_request(CMD_CROSS, 8'd2, 8'd1);
		send_request(CMD_CROSS, 8'd1, 8'd2);
		send_request(CMD_READ, 8'd2, 8'd2);
		send_request(CMD_READ, 8'd3, 8'd2);
		send_request(CMD_READ, 8'd1, 8'd1);
		send_request(CMD_NONE, 8'd255, 8'd255);  // undefined command
		send_request(CMD_CROSS, 8'd200, 8'd200); // prime outside the disk
		send_request(CMD_READ, 8'd200, 8'd200);
		send_request(CMD_CROSS, 8'd255, 8'd0);   // quotient of one
		send_request(CMD_READ, 8'd255, 8'd0);
		// Shrinking the register without a fresh init hides points beyond it.
		write_limit(16'd100);
		send_request(CMD_READ, 8'd7, 8'd3);
		send_request(CMD_READ, 8'd10, 8'd0);
		send_request(CMD_READ, 8'd10, 8'd1);
		send_request(CMD_CROSS, 8'd255, 8'd255);

		// Random phases, each starting from a fresh bitmap.
		k = 0;
		foreach (limits[p]) begin
			write_limit(limits[p]);
			send_request(CMD_INIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			repeat (24) begin
				if (++k > 100) calm = 1;
				random_request();
			end
		end
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d inits, %0d cross-offs, %0d reads, %0d undefined requests",
			n_init, n_cross, n_read, n_other);
		$display("over %0d max_norm settings including 0 and 65535", n_cfg);
		if (failures == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

// File: gaussian_prime_quadrant_sieve.f
design/gpqs_pkg.sv
design/gpqs_div.sv
design/gpqs_bitmap.sv
design/gaussian_prime_quadrant_sieve.sv
dv/gpqs_checker.sv
dv/gaussian_prime_quadrant_sieve_tb.sv
